// File: rtl/fdl_pkg.sv
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types and constants for the feedback comb delay line.
// ----------------------------------------------------------------------------
package fdl_pkg;

   localparam int SAMPLE_WIDTH     = 8;
   localparam int DELAY_LEN_WIDTH  = 7;
   localparam int DELAY_LEN_RANGE  = 1 << DELAY_LEN_WIDTH;
   localparam int GAIN_WIDTH       = 8;
   localparam int GAIN_SHIFT       = 8;
   localparam int CSR_INDEX_WIDTH  = 8;
   localparam int CSR_DATA_WIDTH   = 8;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_DELAY_LENGTH  = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_FEEDBACK_GAIN = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_CLIP_LEVEL    = 8'd2;

   localparam logic [SAMPLE_WIDTH-1:0] CLIP_LEVEL_RESET = 8'hFF;

   typedef logic [SAMPLE_WIDTH-1:0] sample_type;

   // control handed to every cell of the ring
   typedef struct packed {
      logic                       advance;
      logic [DELAY_LEN_WIDTH-1:0] delay_length;
   } cell_ctrl_type;

endpackage

// File: rtl/fdl_cell.sv
// ----------------------------------------------------------------------------
// fdl_cell
// One slot of the rotating delay ring; passes the feedback sample to its
// neighbor when the write position lands on it, otherwise passes its own value.
// ----------------------------------------------------------------------------
module fdl_cell
   import fdl_pkg::*;
#(
   parameter int CELL_INDEX = 0,
   parameter int RING_SIZE  = 128
) (
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  sample_type    feedback_sample,
   input  sample_type    neighbor_sample,
   output sample_type    stored_sample,
   output sample_type    forward_sample
);

   sample_type sample_ff;
   sample_type sample_in;
   logic       write_hit;

   // hit when delay_length modulo RING_SIZE equals this slot's offset
   always_comb begin
      write_hit = 1'b0;
      for (int v = CELL_INDEX; v < DELAY_LEN_RANGE; v += RING_SIZE) begin
         write_hit = write_hit | (ctrl.delay_length == DELAY_LEN_WIDTH'(v));
      end
   end

   assign forward_sample = write_hit ? feedback_sample : sample_ff;
   assign sample_in      = ctrl.advance ? neighbor_sample : sample_ff;
   assign stored_sample  = sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in;
      end
   end

endmodule

// File: rtl/feedback_delay_line_8bit_top.sv
// ----------------------------------------------------------------------------
// feedback_delay_line_8bit_top
// Feedback comb delay line for unsigned 8-bit samples.
// ----------------------------------------------------------------------------
// The block takes one dry sample per beat and returns one wet sample per
// beat, at a sustained rate of one sample per clock while rsp_ready drains
// the output; the registered result appears in the cycle after the beat is
// accepted. The delay store is a ring of RING_SIZE cells that rotates by one
// slot per accepted sample, so the oldest sample always sits in cell 0; the
// read of cell 0, the add and clip, the 8x8 gain multiply and the feedback
// write all complete in the accept cycle. The output register holds one
// result and the input is accepted whenever that register is empty or is
// being drained in the same cycle. The store is cleared by reset directly,
// with no clearing pass. Configuration is taken at any time through the csr
// port, one register per beat; unknown indexes are ignored.
module feedback_delay_line_8bit_top
   import fdl_pkg::*;
#(
   parameter int RING_SIZE = 128
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [SAMPLE_WIDTH-1:0]    req_dry_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [SAMPLE_WIDTH-1:0]    rsp_wet_sample,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   logic [DELAY_LEN_WIDTH-1:0] delay_length_ff;
   logic [GAIN_WIDTH-1:0]      feedback_gain_ff;
   sample_type                 clip_level_ff;

   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   sample_type                 wet_sample_ff;
   sample_type                 wet_sample_in;

   logic                       accept;
   cell_ctrl_type              cell_ctrl;
   logic [SAMPLE_WIDTH:0]      sum;
   logic [SAMPLE_WIDTH+GAIN_WIDTH-1:0] product;
   sample_type                 feedback_sample;

   sample_type                 stored [RING_SIZE];
   sample_type                 forward [RING_SIZE];

   assign csr_ready = 1'b1;
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign cell_ctrl.advance      = accept;
   assign cell_ctrl.delay_length = delay_length_ff;

   // wet sample from the oldest slot plus the dry sample, clipped; dry sample alone at zero delay
   always_comb begin
      sum = {1'b0, stored[0]} + {1'b0, req_dry_sample};
      if (delay_length_ff == '0) begin
         wet_sample_in = req_dry_sample;
      end else if (sum > {1'b0, clip_level_ff}) begin
         wet_sample_in = clip_level_ff;
      end else begin
         wet_sample_in = sum[SAMPLE_WIDTH-1:0];
      end
   end

   assign product = wet_sample_in * feedback_gain_ff;
   assign feedback_sample = product[GAIN_SHIFT +: SAMPLE_WIDTH];

   genvar k;
   generate
      for (k = 0; k < RING_SIZE; k++) begin : g_cell
         sample_type neighbor;
         if (k == RING_SIZE - 1) begin : g_wrap
            assign neighbor = forward[0];
         end else begin : g_chain
            assign neighbor = forward[k+1];
         end
         fdl_cell #(
            .CELL_INDEX (k),
            .RING_SIZE  (RING_SIZE)
         ) u_cell (
            .clock           (clock),
            .reset           (reset),
            .ctrl            (cell_ctrl),
            .feedback_sample (feedback_sample),
            .neighbor_sample (neighbor),
            .stored_sample   (stored[k]),
            .forward_sample  (forward[k])
         );
      end
   endgenerate

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff     <= 1'b0;
         delay_length_ff  <= '0;
         feedback_gain_ff <= '0;
         clip_level_ff    <= CLIP_LEVEL_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_DELAY_LENGTH:  delay_length_ff  <= csr_data[DELAY_LEN_WIDTH-1:0];
               REG_FEEDBACK_GAIN: feedback_gain_ff <= csr_data[GAIN_WIDTH-1:0];
               REG_CLIP_LEVEL:    clip_level_ff    <= csr_data[SAMPLE_WIDTH-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wet_sample_ff <= wet_sample_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_wet_sample = wet_sample_ff;

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted beat produced no result");

   a_dry_passthrough: assert property (@(posedge clock) disable iff (reset)
      (accept && delay_length_ff == '0) |=> rsp_wet_sample == $past(req_dry_sample))
      else $error("zero delay did not pass the dry sample");

   a_clip_respected: assert property (@(posedge clock) disable iff (reset)
      (accept && delay_length_ff != '0) |=> rsp_wet_sample <= $past(clip_level_ff))
      else $error("wet sample above clip level");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("input stalled with empty output register");

endmodule
